>>> hdl/rdq_pkg.sv
// rdq_pkg: shared constants, codes and helpers for the ring deque message store
// no dependencies; compile first

package rdq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int SLOT_BYTES_DEF = 8;

    localparam int DATA_W  = 64;
    localparam int SIZE_W  = 8;
    localparam int CNT_W   = 5;
    localparam int LEN_W   = 4;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_CAPACITY      = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ELEMENT_BYTES = 2'd1;

    typedef logic [DATA_W-1:0] data_t;

    // keeps the low nbytes bytes, nbytes of 8 or more keeps all
    function automatic data_t byte_mask(input logic [LEN_W-1:0] nbytes);
        data_t m;
        m = '0;
        for (int b = 0; b < DATA_W / 8; b++)
        begin
            if (LEN_W'(b) < nbytes)
            begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

>>> hdl/rdq_if.sv
// rdq_if: valid/ready channels of the ring deque message store (request, response, config)
// depends on rdq_pkg

interface rdq_req_if;
    import rdq_pkg::*;
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [DATA_W-1:0]   msg_data;
    logic [SIZE_W-1:0]   msg_size;
    modport source (output valid, output req_type, output msg_data, output msg_size,
                    input ready);
    modport sink (input valid, input req_type, input msg_data, input msg_size,
                  output ready);
endinterface

interface rdq_rsp_if;
    import rdq_pkg::*;
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [DATA_W-1:0]   out_data;
    logic [CNT_W-1:0]    occupancy;
    modport source (output valid, output status, output out_data, output occupancy,
                    input ready);
    modport sink (input valid, input status, input out_data, input occupancy,
                  output ready);
endinterface

interface rdq_cfg_if;
    import rdq_pkg::*;
    logic                valid;
    logic                ready;
    logic [CIDX_W-1:0]   index;
    logic [CDATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/rdq_ram.sv
// rdq_ram: generic single-write, single-read synchronous RAM with registered read
// no dependencies

module rdq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/ring_deque_message_store.sv
// ring_deque_message_store: fixed-slot circular double-ended message queue
// depends on rdq_pkg, rdq_if (channels) and rdq_ram (slot memory)

// One request at a time: a push, or any request rejected for size, full or
// empty, is answered the cycle after it is accepted; a successful pop first
// reads the slot RAM and fills the response register in S_READ. The response
// sits in an output register, so a new request is taken in the same cycle the
// previous response is consumed. Slots hold no reset value and need no
// clearing pass; indices and the fill count clear on reset. Capacity 0 acts
// as 1, capacity above DEPTH acts as DEPTH, element length above SLOT_BYTES
// acts as SLOT_BYTES. Config writes are always taken and should land while idle.

module ring_deque_message_store #(
    parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
    parameter int SLOT_BYTES = rdq_pkg::SLOT_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rdq_req_if.sink    req,
    rdq_rsp_if.source  rsp,
    rdq_cfg_if.sink    cfg
);
    import rdq_pkg::*;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int SLOT_W  = 8 * SLOT_BYTES;
    localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
    localparam int CMP_W   = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
    localparam logic [CNT_W-1:0] CAP_LIM  = CAP_MAX[CNT_W-1:0];
    localparam logic [LEN_W-1:0] LEN_LIM  = LEN_W'(SLOT_BYTES);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic               state_reg, state_next;
    logic [CNT_W-1:0]   cap_reg;
    logic [LEN_W-1:0]   elem_reg;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [LEN_W-1:0]   size_reg, size_next;

    logic               rsp_valid_reg, rsp_valid_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    data_t              data_reg, data_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;

    logic [CNT_W-1:0]   eff_cap;
    logic [LEN_W-1:0]   eff_len;
    logic [CMP_W-1:0]   head_p1, tail_p1;
    logic [IDX_W-1:0]   head_inc, head_dec, tail_inc, tail_dec, cap_last;
    logic               accept, too_long, is_push, full, empty;

    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [SLOT_W-1:0]  ram_wdata, ram_rdata;

    // ---------------------------------------------------------------- config
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CNT_W'(16);
            elem_reg <= LEN_W'(8);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CAPACITY:      cap_reg  <= cfg.data[CNT_W-1:0];
                CFG_ELEMENT_BYTES: elem_reg <= cfg.data[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = CNT_W'(1);
        else if (cap_reg > CAP_LIM)
            eff_cap = CAP_LIM;
        else
            eff_cap = cap_reg;
        eff_len = (elem_reg > LEN_LIM) ? LEN_LIM : elem_reg;
    end

    // ---------------------------------------------------------------- index math
    assign cap_last = IDX_W'(eff_cap - CNT_W'(1));
    assign head_p1  = CMP_W'(head_reg) + CMP_W'(1);
    assign tail_p1  = CMP_W'(tail_reg) + CMP_W'(1);
    assign head_inc = (head_p1 >= CMP_W'(eff_cap)) ? '0 : head_p1[IDX_W-1:0];
    assign tail_inc = (tail_p1 >= CMP_W'(eff_cap)) ? '0 : tail_p1[IDX_W-1:0];
    // an index left beyond a shrunk capacity also wraps to the last slot
    assign head_dec = (head_reg == '0 || CMP_W'(head_reg) > CMP_W'(eff_cap))
                      ? cap_last : head_reg - IDX_W'(1);
    assign tail_dec = (tail_reg == '0 || CMP_W'(tail_reg) > CMP_W'(eff_cap))
                      ? cap_last : tail_reg - IDX_W'(1);

    // ---------------------------------------------------------------- request
    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign too_long  = req.msg_size > SIZE_W'(eff_len);
    assign is_push   = (req.req_type == REQ_PUSH_BACK) || (req.req_type == REQ_PUSH_FRONT);
    assign full      = fill_reg >= eff_cap;
    assign empty     = fill_reg == '0;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        size_next      = size_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        data_next      = data_reg;
        occ_next       = occ_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = tail_reg;
        ram_raddr      = head_reg;
        ram_wdata      = SLOT_W'(req.msg_data & byte_mask(req.msg_size[LEN_W-1:0]));

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next = 1'b1;
                    data_next      = '0;
                    occ_next       = fill_reg;
                    size_next      = req.msg_size[LEN_W-1:0];
                    if (too_long)
                    begin
                        status_next = ST_TOO_LONG;
                    end
                    else if (is_push)
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            ram_we      = 1'b1;
                            fill_next   = fill_reg + CNT_W'(1);
                            occ_next    = fill_next;
                            if (req.req_type == REQ_PUSH_BACK)
                            begin
                                ram_waddr = tail_reg;
                                tail_next = tail_inc;
                            end
                            else
                            begin
                                ram_waddr = head_dec;
                                head_next = head_dec;
                            end
                        end
                    end
                    else if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        // successful pop: response loads after the slot read
                        rsp_valid_next = 1'b0;
                        status_next    = ST_OK;
                        ram_re         = 1'b1;
                        fill_next      = fill_reg - CNT_W'(1);
                        state_next     = S_READ;
                        if (req.req_type == REQ_POP_FRONT)
                        begin
                            ram_raddr = head_reg;
                            head_next = head_inc;
                        end
                        else
                        begin
                            ram_raddr = tail_dec;
                            tail_next = tail_dec;
                        end
                    end
                end
            end
            S_READ:
            begin
                rsp_valid_next = 1'b1;
                data_next      = DATA_W'(ram_rdata) & byte_mask(size_reg);
                occ_next       = fill_reg;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg   <= size_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        occ_reg    <= occ_next;
    end

    rdq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.out_data  = data_reg;
    assign rsp.occupancy = occ_reg;

    // ---------------------------------------------------------------- checks
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CAP_LIM)
        else $error("fill count above largest capacity");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> !rsp_valid_reg)
        else $error("pop read pending while response register busy");

    a_reject_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && status_reg != ST_OK |-> data_reg == '0)
        else $error("rejected request returned data");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> fill_reg == $past(fill_reg) - CNT_W'(1))
        else $error("pop did not lower fill count by one");

endmodule

>>> tb/ring_deque_message_store_checker.sv
// ring_deque_message_store_checker: watches the request, response and config channels,
// predicts every response of the deque and compares it field by field
// depends on rdq_pkg and rdq_if

module ring_deque_message_store_checker
    import rdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rdq_req_if   req,
    rdq_rsp_if   rsp,
    rdq_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS    = DEPTH_DEF;
    localparam int SLOT_LEN = SLOT_BYTES_DEF;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] out_data;
        logic [CNT_W-1:0]  occupancy;
    } answer_t;

    logic [DATA_W-1:0]  slot_mem [SLOTS];
    int unsigned        head_pos = 0;
    int unsigned        tail_pos = 0;
    int unsigned        fill = 0;
    logic [CDATA_W-1:0] cap_reg = CDATA_W'(16);
    logic [LEN_W-1:0]   len_reg = LEN_W'(8);
    answer_t            answers_due [$];
    int                 errors = 0;

    function automatic int unsigned usable_slots();
        if (cap_reg == 0)
            return 1;
        if (cap_reg > SLOTS)
            return SLOTS;
        return cap_reg;
    endfunction

    function automatic int unsigned usable_len();
        if (len_reg > SLOT_LEN)
            return SLOT_LEN;
        return len_reg;
    endfunction

    function automatic logic [DATA_W-1:0] keep_bytes(input int unsigned n);
        if (n >= DATA_W / 8)
            return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // an index beyond a shrunken capacity wraps to zero going up
    function automatic int unsigned step_up(input int unsigned idx, input int unsigned cap);
        return (idx + 1 >= cap) ? 0 : idx + 1;
    endfunction

    function automatic int unsigned step_down(input int unsigned idx, input int unsigned cap);
        return (idx == 0 || idx > cap) ? cap - 1 : idx - 1;
    endfunction

    function automatic answer_t apply_request(input logic [REQ_W-1:0]  kind,
                                              input logic [DATA_W-1:0] data,
                                              input logic [SIZE_W-1:0] size);
        answer_t     a;
        int unsigned cap;
        cap = usable_slots();
        a.status = ST_OK;
        a.out_data = '0;
        // size check comes before full or empty
        if (size > usable_len())
        begin
            a.status = ST_TOO_LONG;
        end
        else if (kind == REQ_PUSH_BACK || kind == REQ_PUSH_FRONT)
        begin
            if (fill >= cap)
            begin
                a.status = ST_FULL;
            end
            else
            begin
                if (kind == REQ_PUSH_BACK)
                begin
                    slot_mem[tail_pos % SLOTS] = data & keep_bytes(size);
                    tail_pos = step_up(tail_pos, cap);
                end
                else
                begin
                    head_pos = step_down(head_pos, cap);
                    slot_mem[head_pos % SLOTS] = data & keep_bytes(size);
                end
                fill++;
            end
        end
        else if (fill == 0)
        begin
            a.status = ST_EMPTY;
        end
        else
        begin
            if (kind == REQ_POP_FRONT)
            begin
                a.out_data = slot_mem[head_pos % SLOTS];
                head_pos = step_up(head_pos, cap);
            end
            else
            begin
                tail_pos = step_down(tail_pos, cap);
                a.out_data = slot_mem[tail_pos % SLOTS];
            end
            a.out_data &= keep_bytes(size);
            fill--;
        end
        a.occupancy = CNT_W'(fill);
        return a;
    endfunction

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n === 1'b1)
        begin
            if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
            begin
                if (cfg.index == CFG_CAPACITY)
                    cap_reg = cfg.data;
                else if (cfg.index == CFG_ELEMENT_BYTES)
                    len_reg = cfg.data[LEN_W-1:0];
            end
            // response first: it always belongs to an earlier request
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("response with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.out_data !== want.out_data)
                    begin
                        $error("out_data: expected %h, got %h", want.out_data, rsp.out_data);
                        errors++;
                    end
                    if (rsp.occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, rsp.occupancy);
                        errors++;
                    end
                end
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
                answers_due.push_back(apply_request(req.req_type, req.msg_data, req.msg_size));
        end
        pending <= answers_due.size();
        fail_count <= errors;
    end

endmodule

>>> tb/ring_deque_message_store_tb.sv
// ring_deque_message_store_tb: reset, directed and random requests, config phases,
// idle and stall patterns, watchdog and verdict
// depends on rdq_pkg, rdq_if, ring_deque_message_store and its checker

module ring_deque_message_store_tb;
    import rdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 12;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 110;
    localparam int STALL_LIMIT  = 10000;

    // index with no register behind it
    localparam logic [CIDX_W-1:0] CFG_UNMAPPED = 2'd3;

    logic        clk;
    logic        rst_n;
    int          fail_count;
    int          pending;
    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    int unsigned item_len = SLOT_BYTES_DEF;
    int unsigned still_cycles;

    int cap_plan [PHASES] = '{16, 1, 0, 31, 17, 2, 16, 5, 8, 3, 12, 16};
    int len_plan [PHASES] = '{8, 0, 1, 15, 9, 3, 8, 2, 5, 8, 7, 4};

    rdq_req_if req_ch();
    rdq_rsp_if rsp_ch();
    rdq_cfg_if cfg_ch();

    ring_deque_message_store u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    ring_deque_message_store_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        still_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                still_cycles = 0;
            else
                still_cycles++;
            if (still_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // valid stays high into the next item when no gap is drawn
    task automatic send_request(input logic [REQ_W-1:0]  kind,
                                input logic [DATA_W-1:0] data,
                                input logic [SIZE_W-1:0] size);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.msg_data <= data;
        req_ch.msg_size <= size;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
    endtask

    task automatic send_random(input int push_pct);
        int unsigned       pick;
        logic [REQ_W-1:0]  kind;
        logic [SIZE_W-1:0] size;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            // oversized message, any request
            kind = REQ_W'($urandom_range(0, 3));
            size = SIZE_W'($urandom_range(item_len + 1, 255));
        end
        else
        begin
            if ($urandom_range(0, 99) < push_pct)
                kind = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
            else
                kind = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
            size = (pick < 20) ? SIZE_W'(item_len) : SIZE_W'($urandom_range(0, item_len));
        end
        send_request(kind, {$urandom, $urandom}, size);
    endtask

    task automatic write_register(input logic [CIDX_W-1:0]  index,
                                  input logic [CDATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    endtask

    // step past the last handshake first so the last accepted item shows up in pending
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [DATA_W-1:0] pattern;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_PUSH_BACK;
        req_ch.msg_data <= '0;
        req_ch.msg_size <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_CAPACITY;
        cfg_ch.data <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every slot once so no later pop can touch an unwritten one
        for (int i = 0; i < DEPTH_DEF; i++)
        begin
            case (i % 4)
                0: pattern = '1;
                1: pattern = 64'hAAAA_AAAA_AAAA_AAAA;
                2: pattern = 64'h5555_5555_5555_5555;
                default: pattern = {$urandom, $urandom};
            endcase
            send_request((i % 2) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pattern, SIZE_W'(i % 9));
        end
        send_request(REQ_PUSH_BACK, '1, SIZE_W'(0));
        // too long wins over full
        send_request(REQ_PUSH_FRONT, '1, SIZE_W'(9));
        send_request(REQ_POP_FRONT, '0, SIZE_W'(255));
        send_request(REQ_POP_FRONT, '0, SIZE_W'(8));
        send_request(REQ_POP_BACK, '0, SIZE_W'(3));
        send_request(REQ_POP_BACK, '0, SIZE_W'(0));
        send_request(REQ_PUSH_FRONT, '1, SIZE_W'(8));
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 71; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 71; end
                default: begin send_gap_pct = 22; recv_stall_pct = 22; end
            endcase
            if (p >= PHASES - 2)
            begin
                cap_plan[p] = $urandom_range(0, 31);
                len_plan[p] = $urandom_range(0, 15);
            end
            if (p == 0)
                write_register(CFG_UNMAPPED, CDATA_W'($urandom_range(0, 31)));
            // queue contents survive the capacity change
            write_register(CFG_CAPACITY, CDATA_W'(cap_plan[p]));
            write_register(CFG_ELEMENT_BYTES, CDATA_W'(len_plan[p]));
            cfg_ch.valid <= 1'b0;
            item_len = (len_plan[p] > SLOT_BYTES_DEF) ? SLOT_BYTES_DEF : len_plan[p];
            // alternate fill-heavy and drain-heavy stretches to hit full and empty
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_random(((k / 20) % 2) ? 20 : 80);
            settle();
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> ring_deque_message_store.f
hdl/rdq_pkg.sv
hdl/rdq_if.sv
hdl/rdq_ram.sv
hdl/ring_deque_message_store.sv
tb/ring_deque_message_store_checker.sv
tb/ring_deque_message_store_tb.sv
